FILE: rtl/lvfp_pkg.sv
package lvfp_pkg;

	localparam int LABEL_LIM_W = 6;
	localparam int VALUE_LIM_W = 7;
	localparam int FIELD_LIM_W = 8;
	localparam int OFFSET_W    = 7;
	localparam int COUNT_W     = 8;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [LABEL_LIM_W-1:0] LABEL_LIM_RST = 6'd9;
	localparam logic [VALUE_LIM_W-1:0] VALUE_LIM_RST = 7'd33;
	localparam logic [FIELD_LIM_W-1:0] FIELD_LIM_RST = 8'd32;

	localparam logic [1:0] REG_LABEL_LIMIT = 2'd0;
	localparam logic [1:0] REG_VALUE_LIMIT = 2'd1;
	localparam logic [1:0] REG_FIELD_LIMIT = 2'd2;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;

	localparam logic [OFFSET_W-1:0] CK_NAME_LEN = 7'd8;
	localparam logic [7:0] CK_NAME [8] = '{8'h43, 8'h68, 8'h65, 8'h63,
		8'h6b, 8'h73, 8'h75, 8'h6d};

	typedef enum logic [5:0] {
		PS_START   = 6'b000001,
		PS_LABEL   = 6'b000010,
		PS_VALUE   = 6'b000100,
		PS_CKSUM   = 6'b001000,
		PS_NEWLINE = 6'b010000,
		PS_ERROR   = 6'b100000
	} parse_state_t;

	typedef enum logic [3:0] {
		R_LABEL   = 4'd0,
		R_TAB     = 4'd1,
		R_VALUE   = 4'd2,
		R_FIELD   = 4'd3,
		R_OK      = 4'd4,
		R_BAD     = 4'd5,
		R_BREAK   = 4'd6,
		R_OVER    = 4'd7,
		R_DISCARD = 4'd8,
		R_CLEARED = 4'd9
	} role_t;

	typedef struct packed {
		logic [LABEL_LIM_W-1:0] label_limit;
		logic [VALUE_LIM_W-1:0] value_limit;
		logic [FIELD_LIM_W-1:0] field_limit;
	} lvfp_cfg_t;

	typedef struct packed {
		role_t               role;
		logic [OFFSET_W-1:0] position;
		logic [COUNT_W-1:0]  fields;
	} lvfp_res_t;

endpackage

FILE: rtl/label_value_frame_parser_core.sv
// Channel  Handshake                  Payload
// in       in_valid / in_ready        byte_in
// out      out_valid / out_ready      byte_out, role, position, fields_seen
// cfg      psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A request is held in the input register until the result register can take
// it, and is then parsed into the result register, where its result stays
// valid until out_ready takes it.
// With out_ready high, one byte per cycle is sustained; the parser state
// is updated once per byte as it moves from input to result register.
// Reset clears the parser state and loads the default limits.
// A stalled result holds the input register, and in_ready drops only when
// both registers are full and out_ready is low.
module label_value_frame_parser_core
	import lvfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        byte_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        byte_out,
	output logic [3:0]        role,
	output logic [6:0]        position,
	output logic [7:0]        fields_seen,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	lvfp_cfg_t  cfg;
	lvfp_res_t  res;
	lvfp_res_t  res_q;
	logic [7:0] byte_s1;
	logic [7:0] byte_q;
	logic       valid_s1;
	logic       out_valid_q;
	logic       out_load;
	logic       advance;

	assign out_load = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_load;
	assign in_ready = !valid_s1 || out_load;

	lvfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lvfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.byte_s1 (byte_s1),
		.advance (advance),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_s1;
			res_q  <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_out    = byte_q;
	assign role        = res_q.role;
	assign position    = res_q.position;
	assign fields_seen = res_q.fields;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input not ready with empty input register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a byte while stalled");

	a_ok_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (role == R_OK || role == R_CLEARED) |-> fields_seen == 8'h00)
		else $error("field count not cleared on block ok or error clear");

	a_role_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> role <= R_CLEARED)
		else $error("undefined role code");

endmodule

FILE: rtl/lvfp_cfg.sv
module lvfp_cfg
	import lvfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output lvfp_cfg_t         cfg
);

	lvfp_cfg_t  cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.label_limit <= LABEL_LIM_RST;
			cfg_q.value_limit <= VALUE_LIM_RST;
			cfg_q.field_limit <= FIELD_LIM_RST;
		end else if (wr_en) begin
			// Writes to an address past the last register are dropped.
			unique case (reg_idx)
				REG_LABEL_LIMIT: cfg_q.label_limit <= pwdata[LABEL_LIM_W-1:0];
				REG_VALUE_LIMIT: cfg_q.value_limit <= pwdata[VALUE_LIM_W-1:0];
				REG_FIELD_LIMIT: cfg_q.field_limit <= pwdata[FIELD_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_LABEL_LIMIT: prdata[LABEL_LIM_W-1:0] = cfg_q.label_limit;
			REG_VALUE_LIMIT: prdata[VALUE_LIM_W-1:0] = cfg_q.value_limit;
			REG_FIELD_LIMIT: prdata[FIELD_LIM_W-1:0] = cfg_q.field_limit;
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/lvfp_parse.sv
module lvfp_parse
	import lvfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lvfp_cfg_t  cfg,
	input  logic [7:0] byte_s1,
	input  logic       advance,
	output lvfp_res_t  res
);

	parse_state_t        ps_q, n_ps, lb_ps;
	logic [OFFSET_W-1:0] off_q, n_off, lb_off, off_in;
	logic [7:0]          sum_q, n_sum, sum1;
	logic [COUNT_W-1:0]  fcnt_q, n_fcnt, lb_fcnt;
	logic                match_q, n_match, lb_match;
	role_t               n_role, lb_role;
	logic [OFFSET_W-1:0] n_pos;
	logic                is_crlf, is_cr, is_tab;
	logic [COUNT_W:0]    fcnt_inc;

	assign is_cr    = (byte_s1 == CH_CR);
	assign is_crlf  = is_cr || (byte_s1 == CH_LF);
	assign is_tab   = (byte_s1 == CH_TAB);
	assign sum1     = sum_q + byte_s1;
	assign fcnt_inc = {1'b0, fcnt_q} + {{COUNT_W{1'b0}}, 1'b1};

	// Label byte handling; a fresh label starts from offset zero.
	always_comb begin
		off_in   = (ps_q == PS_LABEL) ? off_q : '0;
		lb_ps    = ps_q;
		lb_off   = off_in;
		lb_match = match_q;
		lb_fcnt  = fcnt_q;
		lb_role  = R_LABEL;
		if (is_tab) begin
			lb_off  = '0;
			lb_role = R_TAB;
			lb_ps   = (match_q && off_in == CK_NAME_LEN) ? PS_CKSUM : PS_VALUE;
		end else if (off_in == {1'b0, cfg.label_limit}) begin
			lb_role = R_OVER;
			if (is_crlf) begin
				lb_fcnt = '0;
				lb_ps   = PS_NEWLINE;
			end else begin
				lb_ps = PS_ERROR;
			end
		end else begin
			if (off_in == '0) begin
				lb_match = (byte_s1 == CK_NAME[0]);
			end else if (off_in < CK_NAME_LEN) begin
				lb_match = match_q && (byte_s1 == CK_NAME[off_in[2:0]]);
			end else begin
				lb_match = 1'b0;
			end
			lb_off = off_in + OFFSET_W'(1);
			lb_ps  = PS_LABEL;
		end
	end

	always_comb begin
		n_ps    = ps_q;
		n_off   = off_q;
		n_sum   = sum1;
		n_fcnt  = fcnt_q;
		n_match = match_q;
		n_role  = R_DISCARD;
		n_pos   = '0;
		unique case (ps_q)
			PS_VALUE: begin
				n_pos = off_q;
				if (is_cr) begin
					if (fcnt_inc > {1'b0, cfg.field_limit}) begin
						n_fcnt = '0;
						n_role = R_OVER;
					end else begin
						n_fcnt = fcnt_inc[COUNT_W-1:0];
						n_role = R_FIELD;
					end
					n_ps = PS_NEWLINE;
				end else if (off_q == cfg.value_limit) begin
					n_role = R_OVER;
					if (is_crlf) begin
						n_fcnt = '0;
						n_ps   = PS_NEWLINE;
					end else begin
						n_ps = PS_ERROR;
					end
				end else begin
					n_off  = off_q + OFFSET_W'(1);
					n_role = R_VALUE;
				end
			end
			PS_CKSUM: begin
				// The checksum byte itself is part of the sum being checked.
				if (sum1 == 8'h00) begin
					n_fcnt = '0;
					n_role = R_OK;
				end else begin
					n_role = R_BAD;
				end
				n_sum = '0;
				n_ps  = PS_NEWLINE;
			end
			PS_ERROR: begin
				if (is_crlf) begin
					n_fcnt = '0;
					n_ps   = PS_NEWLINE;
					n_role = R_CLEARED;
				end else begin
					n_role = R_DISCARD;
				end
			end
			PS_NEWLINE: begin
				if (is_crlf) begin
					n_role = R_BREAK;
				end else begin
					n_ps    = lb_ps;
					n_off   = lb_off;
					n_fcnt  = lb_fcnt;
					n_match = lb_match;
					n_role  = lb_role;
					n_pos   = off_in;
				end
			end
			default: begin
				n_ps    = lb_ps;
				n_off   = lb_off;
				n_fcnt  = lb_fcnt;
				n_match = lb_match;
				n_role  = lb_role;
				n_pos   = off_in;
			end
		endcase
	end

	assign res.role     = n_role;
	assign res.position = n_pos;
	assign res.fields   = n_fcnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q    <= PS_START;
			off_q   <= '0;
			sum_q   <= '0;
			fcnt_q  <= '0;
			match_q <= 1'b0;
		end else if (advance) begin
			ps_q    <= n_ps;
			off_q   <= n_off;
			sum_q   <= n_sum;
			fcnt_q  <= n_fcnt;
			match_q <= n_match;
		end
	end

endmodule

FILE: verif/tb_label_value_frame_parser_core.sv
module tb_label_value_frame_parser_core;
	import lvfp_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int PHASE_ITEMS      = 160;
	localparam int SHORT_LIMITS_ROW = 14;

	typedef struct {
		logic [7:0] data;
		role_t      role;
		logic [6:0] pos;
		logic [7:0] fields;
	} tag_t;

	typedef struct {
		logic [7:0] data;
		bit         fix;
		bit         typed;
		role_t      role;
		logic [6:0] pos;
		logic [7:0] fields;
	} step_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        byte_in;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        byte_out;
	logic [3:0]        role;
	logic [6:0]        position;
	logic [7:0]        fields_seen;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	label_value_frame_parser_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_in     (byte_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_out    (byte_out),
		.role        (role),
		.position    (position),
		.fields_seen (fields_seen),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Parser mirror and its limits.
	parse_state_t           ps        = PS_START;
	logic [OFFSET_W-1:0]    offs      = '0;
	logic [7:0]             rsum      = '0;
	logic [COUNT_W-1:0]     fcount    = '0;
	bit                     ck_match  = 1'b0;
	logic [LABEL_LIM_W-1:0] lim_label = LABEL_LIM_RST;
	logic [VALUE_LIM_W-1:0] lim_value = VALUE_LIM_RST;
	logic [FIELD_LIM_W-1:0] lim_field = FIELD_LIM_RST;

	tag_t        pending_tags[$];
	int          tag_errors      = 0;
	int          sent            = 0;
	int unsigned cycle_count     = 0;
	bit          sender_idles    = 1'b1;
	bit          receiver_stalls = 1'b1;
	bit          squeeze         = 1'b0;
	int          stall_left      = 0;

	step_t script [27] = '{
		'{CH_CR,  0, 1, R_LABEL,   0, 0},
		'{CH_TAB, 0, 1, R_TAB,     1, 0},
		'{CH_CR,  0, 1, R_FIELD,   0, 1},
		'{CH_LF,  0, 1, R_BREAK,   0, 1},
		'{"C",    0, 0, R_LABEL,   0, 0},
		'{"h",    0, 0, R_LABEL,   0, 0},
		'{"e",    0, 0, R_LABEL,   0, 0},
		'{"c",    0, 0, R_LABEL,   0, 0},
		'{"k",    0, 0, R_LABEL,   0, 0},
		'{"s",    0, 0, R_LABEL,   0, 0},
		'{"u",    0, 0, R_LABEL,   0, 0},
		'{"m",    0, 0, R_LABEL,   0, 0},
		'{CH_TAB, 0, 0, R_TAB,     0, 0},
		'{8'h00,  1, 1, R_OK,      0, 0},
		'{"A",    0, 1, R_LABEL,   0, 0},
		'{CH_LF,  0, 1, R_OVER,    1, 0},
		'{"x",    0, 1, R_LABEL,   0, 0},
		'{CH_TAB, 0, 1, R_TAB,     1, 0},
		'{"5",    0, 0, R_VALUE,   0, 0},
		'{"6",    0, 1, R_OVER,    1, 0},
		'{8'hff,  0, 1, R_DISCARD, 0, 0},
		'{CH_CR,  0, 1, R_CLEARED, 0, 0},
		'{CH_TAB, 0, 0, R_TAB,     0, 0},
		'{CH_CR,  0, 1, R_FIELD,   0, 1},
		'{"q",    0, 0, R_LABEL,   0, 0},
		'{CH_TAB, 0, 0, R_TAB,     0, 0},
		'{CH_CR,  0, 1, R_OVER,    0, 0}
	};

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic role_t overflow(input logic [7:0] c);
		if (c == CH_CR || c == CH_LF) begin
			fcount = '0;
			ps = PS_NEWLINE;
		end else begin
			ps = PS_ERROR;
		end
		return R_OVER;
	endfunction

	function automatic role_t label_char(input logic [7:0] c, output logic [6:0] pos);
		pos = offs;
		if (c == CH_TAB) begin
			ps = (ck_match && offs == CK_NAME_LEN) ? PS_CKSUM : PS_VALUE;
			offs = '0;
			return R_TAB;
		end
		if (offs == {1'b0, lim_label})
			return overflow(c);
		// The checksum label is matched one character at a time.
		if (offs == '0)
			ck_match = (c == CK_NAME[0]);
		else if (offs < CK_NAME_LEN)
			ck_match = ck_match && (c == CK_NAME[offs[2:0]]);
		else
			ck_match = 1'b0;
		offs = offs + 7'd1;
		ps = PS_LABEL;
		return R_LABEL;
	endfunction

	function automatic tag_t tag_byte(input logic [7:0] c);
		tag_t       t;
		logic [6:0] pos;
		logic [8:0] bumped;
		pos = '0;
		rsum = rsum + c;
		case (ps)
			PS_LABEL: t.role = label_char(c, pos);
			PS_VALUE: begin
				pos = offs;
				if (c == CH_CR) begin
					bumped = fcount + 9'd1;
					if (bumped > {1'b0, lim_field}) begin
						fcount = '0;
						t.role = overflow(c);
					end else begin
						fcount = bumped[7:0];
						ps = PS_NEWLINE;
						t.role = R_FIELD;
					end
				end else if (offs == lim_value) begin
					t.role = overflow(c);
				end else begin
					offs = offs + 7'd1;
					t.role = R_VALUE;
				end
			end
			PS_CKSUM: begin
				if (rsum == 8'd0) begin
					fcount = '0;
					t.role = R_OK;
				end else begin
					t.role = R_BAD;
				end
				rsum = '0;
				ps = PS_NEWLINE;
			end
			PS_NEWLINE: begin
				if (c == CH_CR || c == CH_LF) begin
					t.role = R_BREAK;
				end else begin
					offs = '0;
					t.role = label_char(c, pos);
				end
			end
			PS_ERROR: begin
				if (c == CH_CR || c == CH_LF) begin
					fcount = '0;
					ps = PS_NEWLINE;
					t.role = R_CLEARED;
				end else begin
					t.role = R_DISCARD;
				end
			end
			default: begin
				offs = '0;
				t.role = label_char(c, pos);
			end
		endcase
		t.data = c;
		t.pos = pos;
		t.fields = fcount;
		return t;
	endfunction

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!sender_idles || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_len(input int limit, input int floor_len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(floor_len, (limit < 6) ? limit : 6);
		if (r < 90)
			return $urandom_range(floor_len, limit);
		return limit + 1;
	endfunction

	function automatic logic [7:0] rand_char(input logic [7:0] banned);
		logic [7:0] c;
		c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
		if (c == banned)
			c = "_";
		return c;
	endfunction

	// A fixed byte makes the running sum zero, so the block is accepted.
	task automatic send_byte(input logic [7:0] b, input bit fix);
		int gap;
		gap = sender_gap();
		if (fix)
			b = 8'd0 - rsum;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (!in_ready);
		pending_tags.push_back(tag_byte(b));
		sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_tags.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input int data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= DATA_W'(data);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_limits(input int lbl, input int val, input int fld);
		apb_write({REG_LABEL_LIMIT, 2'b00}, lbl);
		lim_label = LABEL_LIM_W'(lbl);
		apb_write({REG_VALUE_LIMIT, 2'b00}, val);
		lim_value = VALUE_LIM_W'(val);
		apb_write({REG_FIELD_LIMIT, 2'b00}, fld);
		lim_field = FIELD_LIM_W'(fld);
	endtask

	// Mostly well-formed lines and checksum blocks, with some noise.
	task automatic random_burst();
		int r;
		int n;
		int k;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			n = pick_len(int'(lim_label), 1);
			for (k = 0; k < n; k++)
				send_byte(rand_char(CH_TAB), 1'b0);
			send_byte(CH_TAB, 1'b0);
			n = pick_len(int'(lim_value), 0);
			for (k = 0; k < n; k++)
				send_byte(rand_char(CH_CR), 1'b0);
			send_byte(CH_CR, 1'b0);
			if ($urandom_range(0, 9) != 0)
				send_byte(CH_LF, 1'b0);
		end else if (r < 78) begin
			for (k = 0; k < 8; k++)
				send_byte(CK_NAME[k], 1'b0);
			send_byte(CH_TAB, 1'b0);
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0);
			send_byte(CH_CR, 1'b0);
			send_byte(CH_LF, 1'b0);
		end else if (r < 90) begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++)
				send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			n = $urandom_range(1, 8);
			for (k = 0; k < n; k++) begin
				case ($urandom_range(0, 3))
					0: send_byte(CH_TAB, 1'b0);
					1: send_byte(CH_CR, 1'b0);
					2: send_byte(CH_LF, 1'b0);
					default: send_byte(8'($urandom_range(0, 255)), 1'b0);
				endcase
			end
		end
	endtask

	task automatic note_mismatch(input string what, input tag_t want);
		if (tag_errors < 10)
			$display("%s: got byte %h role %0d pos %0d fields %0d, expected byte %h role %0d pos %0d fields %0d",
				what, byte_out, role, position, fields_seen,
				want.data, want.role, want.pos, want.fields);
		tag_errors++;
	endtask

	always @(posedge clk) begin
		tag_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tags.size() == 0) begin
				want = '{8'h00, R_LABEL, 7'd0, 8'd0};
				note_mismatch("result with no request pending", want);
			end else begin
				want = pending_tags.pop_front();
				if (byte_out !== want.data || role !== want.role ||
						position !== want.pos || fields_seen !== want.fields)
					note_mismatch("mismatch", want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request so the block fills up.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (squeeze) begin
				squeeze = 1'b0;
				stall_left = 79;
				out_ready <= 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 99) >= 70) begin
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(7, 30);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		int p;
		int phase_end;
		tag_t t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows run first with the reset limits, then with every limit at one.
		for (i = 0; i < $size(script); i++) begin
			if (i == SHORT_LIMITS_ROW) begin
				settle();
				write_limits(1, 1, 1);
			end
			send_byte(script[i].data, script[i].fix);
			if (script[i].typed) begin
				t = pending_tags[pending_tags.size() - 1];
				t.role = script[i].role;
				t.pos = script[i].pos;
				t.fields = script[i].fields;
				pending_tags[pending_tags.size() - 1] = t;
			end
		end

		for (p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: write_limits(32, 64, 254);
				1: write_limits(1, 1, 1);
				2: write_limits(9, 33, 32);
				3: write_limits(8, 5, 3);
				default: write_limits($urandom_range(1, 32), $urandom_range(1, 64),
					$urandom_range(1, 12));
			endcase
			sender_idles = (p % 3) != 0;
			receiver_stalls = (p % 2) == 0 || p == 5;
			if (p == 2 || p == 4) begin
				sender_idles = 1'b0;
				squeeze = 1'b1;
			end
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end)
				random_burst();
		end

		settle();
		repeat (8) @(posedge clk);
		if (tag_errors == 0 && pending_tags.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
